// ----- rtl/fastbin_heap_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fastbin heap allocator
// Clocked property wrappers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef FASTBIN_HEAP_ALLOCATOR_MACROS_SVH
`define FASTBIN_HEAP_ALLOCATOR_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define FHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define FHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fhal_pkg.sv -----
// ----------------------------------------------------------------------------
// fhal_pkg
// Shared types and constants of the fastbin heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fhal_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned REQ_W  = 10;

  // Default configuration of the heap.
  localparam int unsigned HEAP_BYTES_DEF    = 1024;
  localparam int unsigned HEADER_BYTES_DEF  = 32;
  localparam int unsigned MAX_BIN_CHUNK_DEF = 128;
  localparam int unsigned BIN_COUNT_DEF     = 16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] user_address;
    status_t           status;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/fastbin_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// fastbin_heap_allocator
// Segregated free-list heap allocator with a bump-pointer top region.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// rsp for exactly one cycle with done high, and must be captured then, as the
// block cannot be held off. An allocate that is refused, an allocate that is
// carved from the top region, and a free that is refused, pass through the
// look state alone before the next item can be taken; an allocate that pops a
// free list, and a free that pushes its chunk onto a list, pass through the
// look and finish states. The extra state is set by the chain of dependent
// reads through the synchronous stores: a pop reads the bin head and then the link
// stored at that head, and a free reads the chunk size and then the head of
// the bin that the size selects. The result strobe rises in the cycle in
// which busy falls. There is no clearing pass after reset: bin heads carry
// valid bits, and the link and size stores hold nothing of meaning until a
// chunk has been carved or freed.
// ----------------------------------------------------------------------------
`default_nettype none

module fastbin_heap_allocator #(
  parameter int unsigned HEAP_BYTES    = fhal_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = fhal_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BIN_CHUNK = fhal_pkg::MAX_BIN_CHUNK_DEF,
  parameter int unsigned BIN_COUNT     = fhal_pkg::BIN_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire fhal_pkg::req_t req,
  output logic                done,
  output fhal_pkg::rsp_t      rsp
);

  // Offsets carry one spare code so that HEAP_BYTES itself can mark an
  // empty bin. The needed size is the request plus the header, which always
  // fits in one bit more than the request field.
  localparam int unsigned OFS_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned HIDX_W = $clog2(HEAP_BYTES);
  localparam int unsigned SIZE_W = $clog2(MAX_BIN_CHUNK + 1);
  localparam int unsigned BIN_W  = $clog2(BIN_COUNT);
  localparam int unsigned NEED_W = fhal_pkg::REQ_W + 1;
  localparam int unsigned ADDR_W = fhal_pkg::ADDR_W;

  // Bin of a chunk size: size rounded up to 8-byte units, less one, with an
  // index beyond the last bin folded onto the last bin.
  function automatic logic [BIN_W-1:0] bin_of(input logic [NEED_W-1:0] size);
    logic [NEED_W:0] units;
    units = ({1'b0, size} + (NEED_W + 1)'(7)) >> 3;
    units = units - (NEED_W + 1)'(1);
    if (units >= (NEED_W + 1)'(BIN_COUNT)) begin
      return BIN_W'(BIN_COUNT - 1);
    end
    return units[BIN_W-1:0];
  endfunction

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FINISH
  } state_t;

  state_t               state;
  fhal_pkg::opcode_t    op;
  logic [NEED_W-1:0]    need;
  logic                 too_big;
  logic                 bad_addr;
  logic [BIN_W-1:0]     bin;
  logic [HIDX_W-1:0]    chunk;
  logic [OFS_W-1:0]     head;
  logic [OFS_W-1:0]     top_offset;
  logic [OFS_W-1:0]     top_size;

  // Request decode in the cycle of acceptance.
  logic [NEED_W-1:0]       need_in;
  logic [ADDR_W-1:0]       chunk_in;
  logic                    bad_addr_in;
  logic                    accept;

  assign accept      = start && !busy;
  assign need_in     = NEED_W'(req.request_bytes) + NEED_W'(HEADER_BYTES);
  assign chunk_in    = req.free_address - ADDR_W'(HEADER_BYTES);
  assign bad_addr_in = (req.free_address < ADDR_W'(HEADER_BYTES)) ||
                       (32'(chunk_in) >= 32'(HEAP_BYTES));

  // Store ports.
  logic [BIN_W-1:0]  bin_raddr;
  logic [OFS_W-1:0]  bin_rdata;
  logic              bin_we;
  logic [OFS_W-1:0]  bin_wdata;
  logic [OFS_W-1:0]  link_rdata;
  logic              link_we;
  logic [SIZE_W-1:0] size_rdata;
  logic              size_we;

  // Decisions taken once the first read has returned.
  logic              head_live;
  logic              top_short;
  logic              size_bad;
  logic [BIN_W-1:0]  size_bin;

  assign head_live = bin_rdata < OFS_W'(HEAP_BYTES);
  assign top_short = 32'(top_size) < 32'(need);
  assign size_bad  = (size_rdata == '0) || (size_rdata > SIZE_W'(MAX_BIN_CHUNK));
  assign size_bin  = bin_of(NEED_W'(size_rdata));

  // The head read is addressed by the request's bin on an allocate, and by
  // the bin of the stored size on the second step of a free.
  assign bin_raddr = (state == S_IDLE) ? bin_of(need_in) : size_bin;

  assign size_we = (state == S_LOOK) && (op == fhal_pkg::OP_ALLOC) && !too_big &&
                   !head_live && !top_short;
  assign link_we = (state == S_FINISH) && (op == fhal_pkg::OP_FREE);
  assign bin_we  = (state == S_FINISH);
  // A pop moves the head on to the stored link; a free makes the chunk the
  // new head, its link written with the old head in that same cycle.
  assign bin_wdata = (op == fhal_pkg::OP_ALLOC) ? link_rdata : OFS_W'(chunk);

  fhal_bin_mem #(
    .HEAP_BYTES (HEAP_BYTES),
    .BIN_COUNT  (BIN_COUNT)
  ) u_bin_mem (
    .clk   (clk),
    .rst   (rst),
    .raddr (bin_raddr),
    .rdata (bin_rdata),
    .we    (bin_we),
    .waddr (bin),
    .wdata (bin_wdata)
  );

  fhal_chunk_mem #(
    .HEAP_BYTES    (HEAP_BYTES),
    .MAX_BIN_CHUNK (MAX_BIN_CHUNK)
  ) u_chunk_mem (
    .clk        (clk),
    .link_we    (link_we),
    .link_waddr (chunk),
    .link_wdata (bin_rdata),
    .link_raddr (HIDX_W'(bin_rdata)),
    .link_rdata (link_rdata),
    .size_we    (size_we),
    .size_waddr (HIDX_W'(top_offset)),
    .size_wdata (SIZE_W'(need)),
    .size_raddr (HIDX_W'(chunk_in)),
    .size_rdata (size_rdata)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      top_offset <= '0;
      top_size   <= OFS_W'(HEAP_BYTES - HEADER_BYTES);
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req.opcode;
            need     <= need_in;
            too_big  <= need_in > NEED_W'(MAX_BIN_CHUNK);
            bad_addr <= bad_addr_in;
            bin      <= bin_of(need_in);
            chunk    <= HIDX_W'(chunk_in);
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (op == fhal_pkg::OP_ALLOC) begin
            if (too_big) begin
              rsp   <= '{user_address: '0, status: fhal_pkg::ST_TOO_LARGE};
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (head_live) begin
              head  <= bin_rdata;
              state <= S_FINISH;
            end else if (top_short) begin
              rsp   <= '{user_address: '0, status: fhal_pkg::ST_EXHAUSTED};
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              // Carve from the top region; the size is stored alongside.
              top_offset <= OFS_W'(32'(top_offset) + 32'(need));
              top_size   <= OFS_W'(32'(top_size) - 32'(need));
              rsp   <= '{user_address: ADDR_W'(32'(top_offset) + 32'(HEADER_BYTES)),
                         status: fhal_pkg::ST_OK};
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            if (bad_addr || size_bad) begin
              rsp   <= '{user_address: '0, status: fhal_pkg::ST_BAD_FREE};
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              bin   <= size_bin;
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (op == fhal_pkg::OP_ALLOC) begin
            rsp <= '{user_address: ADDR_W'(32'(head) + 32'(HEADER_BYTES)),
                     status: fhal_pkg::ST_OK};
          end else begin
            rsp <= '{user_address: '0, status: fhal_pkg::ST_OK};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fhal_bin_mem.sv -----
// ----------------------------------------------------------------------------
// fhal_bin_mem
// Bin head store: one head offset per bin, synchronous read, valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fhal_bin_mem #(
  parameter int unsigned HEAP_BYTES = fhal_pkg::HEAP_BYTES_DEF,
  parameter int unsigned BIN_COUNT  = fhal_pkg::BIN_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [$clog2(BIN_COUNT)-1:0]      raddr,
  output logic      [$clog2(HEAP_BYTES+1)-1:0]   rdata,
  input  wire logic                              we,
  input  wire logic [$clog2(BIN_COUNT)-1:0]      waddr,
  input  wire logic [$clog2(HEAP_BYTES+1)-1:0]   wdata
);

  localparam int unsigned OFS_W = $clog2(HEAP_BYTES + 1);

  logic [OFS_W-1:0]     mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] valid;
  logic [OFS_W-1:0]     mem_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // A bin that has never been pushed reads as the empty marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : OFS_W'(HEAP_BYTES);

endmodule

`default_nettype wire

// ----- rtl/fhal_chunk_mem.sv -----
// ----------------------------------------------------------------------------
// fhal_chunk_mem
// Per-chunk link and size stores, each with one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fhal_chunk_mem #(
  parameter int unsigned HEAP_BYTES    = fhal_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_BIN_CHUNK = fhal_pkg::MAX_BIN_CHUNK_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                link_we,
  input  wire logic [$clog2(HEAP_BYTES)-1:0]       link_waddr,
  input  wire logic [$clog2(HEAP_BYTES+1)-1:0]     link_wdata,
  input  wire logic [$clog2(HEAP_BYTES)-1:0]       link_raddr,
  output logic      [$clog2(HEAP_BYTES+1)-1:0]     link_rdata,
  input  wire logic                                size_we,
  input  wire logic [$clog2(HEAP_BYTES)-1:0]       size_waddr,
  input  wire logic [$clog2(MAX_BIN_CHUNK+1)-1:0]  size_wdata,
  input  wire logic [$clog2(HEAP_BYTES)-1:0]       size_raddr,
  output logic      [$clog2(MAX_BIN_CHUNK+1)-1:0]  size_rdata
);

  localparam int unsigned OFS_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SIZE_W = $clog2(MAX_BIN_CHUNK + 1);

  logic [OFS_W-1:0]  link_mem [HEAP_BYTES];
  logic [SIZE_W-1:0] size_mem [HEAP_BYTES];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_rdata <= size_mem[size_raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/fhal_checker.sv -----
// ----------------------------------------------------------------------------
// fhal_checker
// Port-level checks of the fastbin heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fastbin_heap_allocator_macros.svh"

module fhal_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire fhal_pkg::req_t req,
  input wire logic           done,
  input wire fhal_pkg::rsp_t rsp
);

  logic accept;
  logic opcode_seen;
  logic rsp_error;
  logic rsp_null;

  assign accept      = start && !busy;
  assign opcode_seen = (req.opcode == fhal_pkg::OP_FREE);
  assign rsp_error   = done && (rsp.status != fhal_pkg::ST_OK);
  assign rsp_null    = (rsp.user_address == '0);

  // An accepted item always raises busy in the cycle after it is taken.
  `FHA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted item did not raise busy")

  // A result is delivered exactly when the block finishes its work.
  `FHA_ASSERT_NOW(a_done_on_finish, clk, rst, done, !busy && $past(busy), "result without work")

  `FHA_ASSERT_NOW(a_finish_gives_done, clk, rst, $fell(busy), done, "work ended with no result")

  // Every refused request returns a null address.
  `FHA_ASSERT_NOW(a_error_null, clk, rst, rsp_error, rsp_null, "error result carries an address")

  // A free cannot finish in the cycle after it is taken, as its stored size
  // has to be read first.
  `FHA_ASSERT_NEXT(a_free_null, clk, rst, accept && opcode_seen, !done, "free finished too early")

endmodule

bind fastbin_heap_allocator fhal_checker u_fhal_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
